FILE: design/ofr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Obfuscated frame receiver package
// Shared constants, codes, types, the XOR key table and the CRC byte update.
// ----------------------------------------------------------------------------
package ofr_pkg;

    localparam logic [7:0] START0_BYTE = 8'hAB;
    localparam logic [7:0] START1_BYTE = 8'hCD;
    localparam logic [7:0] FOOT0_BYTE  = 8'hDC;
    localparam logic [7:0] FOOT1_BYTE  = 8'hBA;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd8;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [1:0] CFG_BUFFER_SIZE   = 2'd0;
    localparam logic [1:0] CFG_DEOBF_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_CRC_POLY      = 2'd2;
    localparam logic [1:0] CFG_CRC_INIT      = 2'd3;

    localparam logic [15:0] RST_BUFFER_SIZE  = 16'd256;
    localparam logic        RST_DEOBF_ENABLE = 1'b1;
    localparam logic [15:0] RST_CRC_POLY     = 16'h1021;
    localparam logic [15:0] RST_CRC_INIT     = 16'h0000;

    localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
    localparam logic [2:0] KIND_GOOD       = 3'd1;
    localparam logic [2:0] KIND_CRC_BAD    = 3'd2;
    localparam logic [2:0] KIND_FOOTER_BAD = 3'd3;
    localparam logic [2:0] KIND_TOO_LARGE  = 3'd4;

    typedef enum logic [1:0] {
        OP_PAYLOAD   = 2'd0,
        OP_TOO_LARGE = 2'd1,
        OP_FOOT_BAD  = 2'd2,
        OP_CHECK     = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] data;
        logic [15:0] index;
        logic [15:0] size;
    } op_entry_t;

    typedef struct packed {
        logic [15:0] buffer_size;
        logic        deobf_enable;
        logic [15:0] crc_poly;
        logic [15:0] crc_init;
    } cfg_t;

    function automatic logic [7:0] xor_key(input logic [3:0] pos);
        logic [7:0] k;
        case (pos)
            4'd0:    k = 8'h16;
            4'd1:    k = 8'h6C;
            4'd2:    k = 8'h14;
            4'd3:    k = 8'hE6;
            4'd4:    k = 8'h2E;
            4'd5:    k = 8'h91;
            4'd6:    k = 8'h0D;
            4'd7:    k = 8'h40;
            4'd8:    k = 8'h21;
            4'd9:    k = 8'h35;
            4'd10:   k = 8'hD5;
            4'd11:   k = 8'h40;
            4'd12:   k = 8'h13;
            4'd13:   k = 8'h03;
            4'd14:   k = 8'hE9;
            default: k = 8'h80;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: design/ofr_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface ofr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/ofr_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one payload byte or frame status per beat.
// ----------------------------------------------------------------------------
interface ofr_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_size;
    logic        last;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output frame_size, output last, input ready);
    modport sink (input valid, input kind, input data_byte, input byte_index,
                  input frame_size, input last, output ready);
endinterface

FILE: design/ofr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Hunts for the start pair, tracks the frame layout, removes the XOR key and
// queues payload, status and check operations for the back end.
// ----------------------------------------------------------------------------
module ofr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  ofr_pkg::cfg_t      cfg,
    input  logic               rx_valid,
    input  logic [7:0]         rx_byte,
    output logic               rx_ready,
    input  logic               queue_full,
    output logic               push_valid,
    output ofr_pkg::op_entry_t push_entry
);
    import ofr_pkg::*;

    localparam logic [2:0] PH_HUNT      = 3'd0;
    localparam logic [2:0] PH_GOT_AB    = 3'd1;
    localparam logic [2:0] PH_SIZE_LO   = 3'd2;
    localparam logic [2:0] PH_SIZE_HI   = 3'd3;
    localparam logic [2:0] PH_BODY      = 3'd4;
    localparam logic [2:0] PH_FOOT0     = 3'd5;
    localparam logic [2:0] PH_FOOT1_OK  = 3'd6;
    localparam logic [2:0] PH_FOOT1_BAD = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] crc_rx_reg, crc_rx_next;
    logic        accept;
    logic [7:0]  plain_byte;
    logic [15:0] new_size;

    assign rx_ready   = !queue_full;
    assign accept     = rx_valid && rx_ready;
    assign plain_byte = rx_byte ^ (cfg.deobf_enable ? xor_key(count_reg[3:0]) : 8'h00);
    assign new_size   = {rx_byte, size_reg[7:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        size_next   = size_reg;
        crc_rx_next = crc_rx_reg;
        push_valid  = 1'b0;
        push_entry.op    = OP_PAYLOAD;
        push_entry.data  = {8'h00, plain_byte};
        push_entry.index = count_reg;
        push_entry.size  = size_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == START0_BYTE)
                        phase_next = PH_GOT_AB;
                end
                PH_GOT_AB:
                begin
                    if (rx_byte == START1_BYTE)
                        phase_next = PH_SIZE_LO;
                    else if (rx_byte != START0_BYTE)
                        phase_next = PH_HUNT;
                end
                PH_SIZE_LO:
                begin
                    size_next  = {8'h00, rx_byte};
                    phase_next = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    size_next = new_size;
                    if ({1'b0, new_size} + FRAME_OVERHEAD > {1'b0, cfg.buffer_size})
                    begin
                        push_valid      = 1'b1;
                        push_entry.op   = OP_TOO_LARGE;
                        push_entry.size = new_size;
                        phase_next      = PH_HUNT;
                    end
                    else
                    begin
                        count_next  = 16'd0;
                        crc_rx_next = 16'd0;
                        phase_next  = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (count_reg < size_reg)
                    begin
                        push_valid = 1'b1;
                        count_next = count_reg + 16'd1;
                    end
                    else if (count_reg == size_reg)
                    begin
                        crc_rx_next = {8'h00, plain_byte};
                        count_next  = count_reg + 16'd1;
                    end
                    else
                    begin
                        crc_rx_next = {plain_byte, crc_rx_reg[7:0]};
                        phase_next  = PH_FOOT0;
                    end
                end
                PH_FOOT0:
                begin
                    phase_next = (rx_byte == FOOT0_BYTE) ? PH_FOOT1_OK : PH_FOOT1_BAD;
                end
                PH_FOOT1_OK, PH_FOOT1_BAD:
                begin
                    push_valid      = 1'b1;
                    push_entry.data = crc_rx_reg;
                    if (phase_reg == PH_FOOT1_OK && rx_byte == FOOT1_BYTE)
                        push_entry.op = OP_CHECK;
                    else
                        push_entry.op = OP_FOOT_BAD;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= 16'd0;
            size_reg   <= 16'd0;
            crc_rx_reg <= 16'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            size_reg   <= size_next;
            crc_rx_reg <= crc_rx_next;
        end
    end

endmodule

FILE: design/ofr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operation queue
// Short first-in first-out buffer between the parser and the back end.
// ----------------------------------------------------------------------------
module ofr_queue #(
    parameter int DEPTH = ofr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ofr_pkg::op_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output ofr_pkg::op_entry_t head_entry
);
    import ofr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    op_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = mem_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        if (pop)
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[tail_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/ofr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result stage
// Runs the payload CRC, decides the frame status and holds the result beat.
// ----------------------------------------------------------------------------
module ofr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ofr_pkg::cfg_t      cfg,
    input  logic               queue_empty,
    input  ofr_pkg::op_entry_t head_entry,
    output logic               pop,
    ofr_res_if.source          res
);
    import ofr_pkg::*;

    logic        out_valid_reg;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] index_reg, index_next;
    logic [15:0] size_reg;
    logic        last_reg, last_next;
    logic [15:0] crc_reg, crc_next;
    logic        fresh_reg, fresh_next;
    logic [15:0] crc_base;

    assign pop      = !queue_empty && (!out_valid_reg || res.ready);
    assign crc_base = fresh_reg ? cfg.crc_init : crc_reg;

    always_comb
    begin
        crc_next   = crc_reg;
        fresh_next = fresh_reg;
        kind_next  = KIND_PAYLOAD;
        data_next  = 8'h00;
        index_next = 16'd0;
        last_next  = 1'b1;
        unique case (head_entry.op)
            OP_PAYLOAD:
            begin
                crc_next   = crc_byte(crc_base, head_entry.data[7:0], cfg.crc_poly);
                fresh_next = 1'b0;
                kind_next  = KIND_PAYLOAD;
                data_next  = head_entry.data[7:0];
                index_next = head_entry.index;
                last_next  = 1'b0;
            end
            OP_TOO_LARGE:
            begin
                fresh_next = 1'b1;
                kind_next  = KIND_TOO_LARGE;
            end
            OP_FOOT_BAD:
            begin
                fresh_next = 1'b1;
                kind_next  = KIND_FOOTER_BAD;
            end
            OP_CHECK:
            begin
                fresh_next = 1'b1;
                kind_next  = (crc_base != head_entry.data) ? KIND_CRC_BAD : KIND_GOOD;
            end
            default:
            begin
                fresh_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fresh_reg     <= 1'b1;
            crc_reg       <= 16'd0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                fresh_reg     <= fresh_next;
                crc_reg       <= crc_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            index_reg <= index_next;
            size_reg  <= head_entry.size;
            last_reg  <= last_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.kind       = kind_reg;
    assign res.data_byte  = data_reg;
    assign res.byte_index = index_reg;
    assign res.frame_size = size_reg;
    assign res.last       = last_reg;

endmodule

FILE: design/obfuscated_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Obfuscated frame receiver
// Parses start pair, size, keyed payload, CRC and footer from a byte stream
// and reports each payload byte and one status per frame.
// ----------------------------------------------------------------------------
// Channel  Direction  Beat contents
// rx       in         rx_byte
// res      out        kind, data_byte, byte_index, frame_size, last
// cfg      in         cfg_we, cfg_index, cfg_wdata (write only)
//
// One byte is accepted every cycle while the operation queue has room.
// Each entry passes through the operation queue and then the output register;
// the back end applies the byte-wide CRC update as it pops each payload byte.
// A stall on res fills the queue, after which rx is held off.
// Reset clears the parser, the queue and the output stage at once.
// ----------------------------------------------------------------------------
module obfuscated_frame_receiver #(
    parameter int QUEUE_DEPTH = ofr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    ofr_rx_if.sink      rx,
    ofr_res_if.source   res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import ofr_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      queue_full;
    logic      queue_empty;
    logic      push_valid;
    logic      pop;
    op_entry_t push_entry;
    op_entry_t head_entry;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUFFER_SIZE:  cfg_next.buffer_size  = cfg_wdata;
                CFG_DEOBF_ENABLE: cfg_next.deobf_enable = cfg_wdata[0];
                CFG_CRC_POLY:     cfg_next.crc_poly     = cfg_wdata;
                CFG_CRC_INIT:     cfg_next.crc_init     = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_size  <= RST_BUFFER_SIZE;
            cfg_reg.deobf_enable <= RST_DEOBF_ENABLE;
            cfg_reg.crc_poly     <= RST_CRC_POLY;
            cfg_reg.crc_init     <= RST_CRC_INIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ofr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .rx_valid   (rx.valid),
        .rx_byte    (rx.rx_byte),
        .rx_ready   (rx.ready),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    ofr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .head_entry (head_entry)
    );

    ofr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .head_entry  (head_entry),
        .pop         (pop),
        .res         (res)
    );

endmodule
